// ----- rtl/i2da_pkg.sv -----
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int VALUE_BITS = 32;
   // The magnitude of the most negative value still fits as an unsigned word.
   localparam int MAG_BITS = VALUE_BITS;
   localparam int STEP_BITS = 2;
   localparam int STEPS_PER_DIGIT = 4;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // Number of decimal digits needed for the largest magnitude, 2**(bits-1).
   function automatic int count_digits(input int bits);
      logic [63:0] v;
      int n;
      v = 64'd1 << (bits - 1);
      n = 0;
      for (int i = 0; i < 20; i++) begin
         if (v != 64'd0) begin
            v = v / 64'd10;
            n++;
         end
      end
      return n;
   endfunction

   localparam int DIGITS = count_digits(VALUE_BITS);
   localparam int DIGIT_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   typedef logic [MAG_BITS-1:0] pow_table_type [DIGITS];

   function automatic pow_table_type build_pow10();
      pow_table_type t;
      logic [MAG_BITS-1:0] p;
      p = MAG_BITS'(1);
      for (int i = 0; i < DIGITS; i++) begin
         t[i] = p;
         p = MAG_BITS'(p * 10);
      end
      return t;
   endfunction

   localparam pow_table_type POW10 = build_pow10();

   typedef enum logic {
      ST_IDLE,
      ST_CONV
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic digit_done;
      logic final_digit;
   } ctrl_type;

endpackage

// ----- rtl/i2da_csub.sv -----
// ----------------------------------------------------------------------------
// i2da_csub
// Shared compare and subtract unit: one quotient bit of a decimal digit.
// ----------------------------------------------------------------------------
module i2da_csub (
   input  logic [i2da_pkg::MAG_BITS-1:0]  rem_cur,
   input  logic [i2da_pkg::MAG_BITS-1:0]  pow,
   input  logic [i2da_pkg::STEP_BITS-1:0] shift,
   output logic [i2da_pkg::MAG_BITS-1:0]  rem_next,
   output logic                           quot_bit
);

   logic [i2da_pkg::MAG_BITS+2:0] trial;
   logic [i2da_pkg::MAG_BITS+2:0] rem_wide;

   always_comb begin
      trial    = {3'b000, pow} << shift;
      rem_wide = {3'b000, rem_cur};
      quot_bit = (rem_wide >= trial);
      if (quot_bit) begin
         rem_next = i2da_pkg::MAG_BITS'(rem_wide - trial);
      end else begin
         rem_next = rem_cur;
      end
   end

endmodule

// ----- rtl/i2da_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2da_ctrl
// Sequencer: walks the digit positions and the four quotient bits of each.
// ----------------------------------------------------------------------------
module i2da_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   output i2da_pkg::ctrl_type              ctrl,
   output logic [i2da_pkg::DIGIT_BITS-1:0] digit_idx,
   output logic [i2da_pkg::STEP_BITS-1:0]  bit_idx
);

   i2da_pkg::state_type state_ff, state_in;
   logic [i2da_pkg::DIGIT_BITS-1:0] digit_idx_ff, digit_idx_in;
   logic [i2da_pkg::STEP_BITS-1:0]  bit_idx_ff, bit_idx_in;
   logic last_step;

   assign last_step = (bit_idx_ff == '0) && (digit_idx_ff == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2da_pkg::ST_IDLE: begin
            if (start) begin
               state_in = i2da_pkg::ST_CONV;
            end
         end
         i2da_pkg::ST_CONV: begin
            if (last_step) begin
               state_in = i2da_pkg::ST_IDLE;
            end
         end
         default: state_in = i2da_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy             = (state_ff == i2da_pkg::ST_CONV);
      ctrl.load        = (state_ff == i2da_pkg::ST_IDLE) && start;
      ctrl.step        = (state_ff == i2da_pkg::ST_CONV);
      ctrl.digit_done  = (state_ff == i2da_pkg::ST_CONV) && (bit_idx_ff == '0);
      ctrl.final_digit = (digit_idx_ff == '0);
   end

   always_comb begin
      digit_idx_in = digit_idx_ff;
      bit_idx_in   = bit_idx_ff;
      if (ctrl.load) begin
         digit_idx_in = i2da_pkg::DIGIT_BITS'(i2da_pkg::DIGITS - 1);
         bit_idx_in   = i2da_pkg::STEP_BITS'(i2da_pkg::STEPS_PER_DIGIT - 1);
      end else if (ctrl.step) begin
         bit_idx_in = bit_idx_ff - 1'b1;
         if (bit_idx_ff == '0) begin
            digit_idx_in = digit_idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2da_pkg::ST_IDLE;
         digit_idx_ff <= '0;
         bit_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         digit_idx_ff <= digit_idx_in;
         bit_idx_ff   <= bit_idx_in;
      end
   end

   assign digit_idx = digit_idx_ff;
   assign bit_idx   = bit_idx_ff;

endmodule

// ----- rtl/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, most significant character first.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Transaction
//  request   start, busy, req_value                  start & !busy at the edge
//  response  rsp_valid, rsp_character, rsp_last      one-cycle strobe per character
//
// Each decimal digit is found by restoring division against a power of ten,
// one quotient bit per cycle through one shared compare and subtract unit,
// so busy stays high after a number is accepted until its units digit is done.
// A '-' leaves the cycle after acceptance; each digit leaves the cycle after
// its fourth step. Reset clears the sequencer and the response strobe.
// The receiver cannot stall; the next number may start as the last one ends.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [i2da_pkg::VALUE_BITS-1:0] req_value,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_character,
   output logic                                 rsp_last
);

   i2da_pkg::ctrl_type ctrl;
   logic [i2da_pkg::DIGIT_BITS-1:0] digit_idx;
   logic [i2da_pkg::STEP_BITS-1:0]  bit_idx;

   logic [i2da_pkg::MAG_BITS-1:0] rem_ff, rem_in;
   logic [i2da_pkg::MAG_BITS-1:0] rem_next;
   logic [i2da_pkg::MAG_BITS-1:0] value_bits;
   logic [2:0] digit_ff, digit_in;
   logic       started_ff, started_in;
   logic       quot_bit;
   logic       negative;
   logic [3:0] digit_full;
   logic       emit_digit;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_character_ff, rsp_character_in;
   logic       rsp_last_ff, rsp_last_in;

   i2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .ctrl      (ctrl),
      .digit_idx (digit_idx),
      .bit_idx   (bit_idx)
   );

   i2da_csub u_csub (
      .rem_cur  (rem_ff),
      .pow      (i2da_pkg::POW10[digit_idx]),
      .shift    (bit_idx),
      .rem_next (rem_next),
      .quot_bit (quot_bit)
   );

   assign value_bits = req_value;
   assign negative   = req_value[i2da_pkg::VALUE_BITS-1];
   assign digit_full = {digit_ff, quot_bit};
   // Leading zeros are dropped, but the units digit always goes out.
   assign emit_digit = (digit_full != 4'd0) || started_ff || ctrl.final_digit;

   always_comb begin
      rem_in     = rem_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      if (ctrl.load) begin
         rem_in     = negative ? (i2da_pkg::MAG_BITS'(0) - value_bits) : value_bits;
         digit_in   = 3'd0;
         started_in = 1'b0;
      end else if (ctrl.step) begin
         rem_in = rem_next;
         if (ctrl.digit_done) begin
            digit_in = 3'd0;
            if (digit_full != 4'd0) begin
               started_in = 1'b1;
            end
         end else begin
            digit_in = {digit_ff[1:0], quot_bit};
         end
      end
   end

   always_comb begin
      rsp_valid_in     = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = 1'b0;
      if (ctrl.load && negative) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = i2da_pkg::CHAR_MINUS;
      end else if (ctrl.digit_done && emit_digit) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = i2da_pkg::CHAR_ZERO + {4'b0000, digit_full};
         rsp_last_in      = ctrl.final_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff           <= rem_in;
      digit_ff         <= digit_in;
      started_ff       <= started_in;
      rsp_character_ff <= rsp_character_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- rtl/i2da_checker.sv -----
// ----------------------------------------------------------------------------
// i2da_port_checks
// Port level checks for the integer to decimal text block.
// ----------------------------------------------------------------------------
module i2da_port_checks (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic signed [i2da_pkg::VALUE_BITS-1:0] req_value,
   input logic                                   rsp_valid,
   input logic [7:0]                             rsp_character,
   input logic                                   rsp_last
);

   // An accepted transaction holds the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted transaction");

   // A negative number opens with a minus sign straight away.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_value[i2da_pkg::VALUE_BITS-1] |=>
         rsp_valid && (rsp_character == i2da_pkg::CHAR_MINUS) && !rsp_last)
      else $error("negative number did not open with a minus sign");

   // A non-negative number produces nothing in the cycle after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_value[i2da_pkg::VALUE_BITS-1] |=> !rsp_valid)
      else $error("unexpected character after a non-negative number");

   // Only a minus sign or a decimal digit ever leaves.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == i2da_pkg::CHAR_MINUS) ||
         ((rsp_character >= i2da_pkg::CHAR_ZERO) &&
          (rsp_character <= i2da_pkg::CHAR_NINE)))
      else $error("character out of range");

   // The final character of a number coincides with the block being free and is never a minus sign.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy &&
         (rsp_character != i2da_pkg::CHAR_MINUS))
      else $error("last character while still busy or on a sign");

endmodule

bind int_to_decimal_ascii i2da_port_checks u_checker (.*);
